@@ hdl/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants of the LRU page-frame tracker.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int unsigned CFG_W      = 5;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned LIM_W      = 9;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  // register index, taken from paddr above the byte offset
  localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

@@ hdl/lrupr_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer: take a word, sweep the frame store, drain, then commit.
// ----------------------------------------------------------------------------
module lrupr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  lrupr_pkg::status_t status_i,
  output lrupr_pkg::cmd_t    cmd_o
);
  import lrupr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/lrupr_dp.sv @@
// ----------------------------------------------------------------------------
// lrupr_dp
// Frame store, scan accumulators, counters and result register.
// ----------------------------------------------------------------------------
module lrupr_dp #(
  parameter int unsigned NUM_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 20,
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned OUT_W      = 88
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrupr_pkg::cmd_t             cmd_i,
  output lrupr_pkg::status_t          status_o,
  input  logic [PAGE_BITS-1:0]        page_i,
  input  logic                        is_write_i,
  input  logic                        end_of_trace_i,
  input  logic [lrupr_pkg::CFG_W-1:0] frames_in_use_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [OUT_W-1:0]            m_data_o
);
  import lrupr_pkg::*;

  localparam int unsigned IDX_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned USED_W  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned MEM_W   = PAGE_BITS + 1 + TIME_BITS;
  localparam int unsigned PACK_W  = 3 + PAGE_BITS + 2 * CNT_W;

  // frame store
  logic [MEM_W-1:0]      mem_q [NUM_FRAMES];
  logic [MEM_W-1:0]      rd_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      idx_q;
  logic [NUM_FRAMES-1:0] valid_q, valid_d;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [MEM_W-1:0]      mem_wdata;

  // captured word
  logic [PAGE_BITS-1:0]  page_q;
  logic                  wr_q;
  logic                  last_q;

  // trace state
  logic [TIME_BITS-1:0]  time_q;
  logic [CNT_W-1:0]      fault_q, fault_d;
  logic [CNT_W-1:0]      wb_q, wb_d;

  // scan accumulators
  logic [USED_W-1:0]     used_q;
  logic                  match_found_q, free_found_q, victim_found_q;
  logic [IDX_W-1:0]      match_idx_q, free_idx_q, victim_idx_q;
  logic                  match_dirty_q;
  logic [TIME_BITS-1:0]  oldest_q;
  logic [PAGE_BITS-1:0]  vpage_q;
  logic                  vdirty_q;

  // result register
  logic                  out_valid_q;
  logic                  out_hit_q, out_ev_valid_q, out_ev_dirty_q;
  logic [PAGE_BITS-1:0]  out_ev_page_q;
  logic [CNT_W-1:0]      out_fault_q, out_wb_q;

  logic [PAGE_BITS-1:0]  rd_page;
  logic                  rd_dirty;
  logic [TIME_BITS-1:0]  rd_time;
  logic [TIME_BITS-1:0]  rd_age;
  logic                  rd_live;
  logic [LIM_W-1:0]      limit;
  logic                  use_free;
  logic                  evict;
  logic [PACK_W-1:0]     pack;

  assign rd_page  = rd_q[MEM_W-1 -: PAGE_BITS];
  assign rd_dirty = rd_q[TIME_BITS];
  assign rd_time  = rd_q[TIME_BITS-1:0];
  assign rd_age   = time_q - rd_time;
  assign rd_live  = rd_vld_q && valid_q[rd_idx_q];

  always_comb begin
    limit = LIM_W'(frames_in_use_i);
    if (limit == '0) begin
      limit = LIM_W'(1);
    end else if (limit > LIM_W'(NUM_FRAMES)) begin
      limit = LIM_W'(NUM_FRAMES);
    end
  end

  assign use_free  = (LIM_W'(used_q) < limit) && free_found_q;
  assign evict     = !match_found_q && !use_free;
  assign mem_we    = cmd_i.commit;
  assign mem_waddr = match_found_q ? match_idx_q : (use_free ? free_idx_q : victim_idx_q);
  assign mem_wdata = {page_q, (match_found_q && match_dirty_q) || wr_q, time_q};

  always_comb begin
    fault_d = fault_q;
    wb_d    = wb_q;
    if (!match_found_q && fault_q != '1) begin
      fault_d = fault_q + CNT_W'(1);
    end
    if (evict && vdirty_q && wb_q != '1) begin
      wb_d = wb_q + CNT_W'(1);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.commit) begin
      valid_d[mem_waddr] = 1'b1;
      if (last_q) begin
        valid_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q     <= mem_q[idx_q];
    rd_idx_q <= idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      time_q         <= '0;
      fault_q        <= '0;
      wb_q           <= '0;
      idx_q          <= '0;
      rd_vld_q       <= 1'b0;
      used_q         <= '0;
      match_found_q  <= 1'b0;
      free_found_q   <= 1'b0;
      victim_found_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.capture) begin
        idx_q          <= '0;
        used_q         <= '0;
        match_found_q  <= 1'b0;
        free_found_q   <= 1'b0;
        victim_found_q <= 1'b0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (rd_vld_q) begin
        if (rd_live) begin
          used_q <= used_q + USED_W'(1);
          if (!match_found_q && rd_page == page_q) begin
            match_found_q <= 1'b1;
          end
          if (!victim_found_q || rd_age > oldest_q) begin
            victim_found_q <= 1'b1;
          end
        end else if (!free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          time_q  <= '0;
          fault_q <= '0;
          wb_q    <= '0;
        end else begin
          time_q  <= time_q + TIME_BITS'(1);
          fault_q <= fault_d;
          wb_q    <= wb_d;
        end
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q <= page_i;
      wr_q   <= is_write_i;
      last_q <= end_of_trace_i;
    end
    if (rd_live) begin
      if (!match_found_q && rd_page == page_q) begin
        match_idx_q   <= rd_idx_q;
        match_dirty_q <= rd_dirty;
      end
      if (!victim_found_q || rd_age > oldest_q) begin
        victim_idx_q <= rd_idx_q;
        oldest_q     <= rd_age;
        vpage_q      <= rd_page;
        vdirty_q     <= rd_dirty;
      end
    end else if (rd_vld_q && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      out_hit_q      <= match_found_q;
      out_ev_valid_q <= evict;
      out_ev_page_q  <= evict ? vpage_q : '0;
      out_ev_dirty_q <= evict && vdirty_q;
      out_fault_q    <= fault_d;
      out_wb_q       <= wb_d;
    end
  end

  assign pack = {out_wb_q, out_fault_q, out_ev_dirty_q, out_ev_page_q,
                 out_ev_valid_q, out_hit_q};

  assign m_data_o  = OUT_W'(pack);
  assign m_valid_o = out_valid_q;

  assign status_o.scan_last = (idx_q == IDX_W'(NUM_FRAMES - 1));
  assign status_o.out_free  = !out_valid_q || m_ready_i;

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || m_ready_i))
    else $error("result overwritten before it was taken");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit did not present a result");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_ev_valid_q))
    else $error("hit reported together with an eviction");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= NUM_FRAMES)
    else $error("occupancy count beyond frame count");

endmodule

@@ hdl/lru_page_replacement_dirty_core.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_dirty_core
// Fully associative LRU page-frame tracker with dirty marks and counters.
// ----------------------------------------------------------------------------
// channel  direction  payload (low bit first)
// s_axis   in         tdata: page_number; tuser: is_write; tlast: end_of_trace
// m_axis   out        tdata: hit, evicted_valid, evicted_page, evicted_dirty,
//                            fault_count, writeback_count
// apb      in/out     reg 0 at 0x0: frames_in_use
//
// One access steps through accept, a scan reading one frame per cycle
// from the single-port frame store, a drain state and a commit state.
// Reset empties all frames and clears time and counters; no clearing pass.
// A waiting result stalls only the commit cycle of the following access.
// ----------------------------------------------------------------------------
module lru_page_replacement_dirty_core #(
  parameter  int unsigned NUM_FRAMES = 16,
  parameter  int unsigned PAGE_BITS  = 20,
  parameter  int unsigned TIME_BITS  = 32,
  localparam int unsigned IN_W       = ((PAGE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W      =
    ((3 + PAGE_BITS + 2 * lrupr_pkg::CNT_W + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [IN_W-1:0]                  s_axis_tdata,  // page_number
  input  logic                             s_axis_tuser,  // is_write
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hit, evicted_valid, evicted_page, evicted_dirty, fault_count, writeback_count
  output logic [OUT_W-1:0]                 m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lrupr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lrupr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lrupr_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0] frames_q;
  logic             reg_hit;
  cmd_t             cmd;
  status_t          status;

  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(frames_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FRAMES_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      frames_q <= pwdata[CFG_W-1:0];
    end
  end

  lrupr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lrupr_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .TIME_BITS  (TIME_BITS),
    .OUT_W      (OUT_W)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .page_i          (s_axis_tdata[PAGE_BITS-1:0]),
    .is_write_i      (s_axis_tuser),
    .end_of_trace_i  (s_axis_tlast),
    .frames_in_use_i (frames_q),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_data_o        (m_axis_tdata)
  );

endmodule

@@ tb/sv/tb_lru_page_replacement_dirty_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement_dirty_core
// Streams page accesses into the LRU frame tracker and checks every reply
// word against an in-bench prediction of frames, dirty marks, evictions and
// counters. The frame limit is set over APB between phases, with
// out-of-range values, a limit lowered below occupancy and random stalls on
// both stream sides.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_dirty_core;
  import lrupr_pkg::*;

  localparam int unsigned FRAMES     = 16;
  localparam int unsigned PAGE_W     = 20;
  localparam int unsigned IN_W       = 24;
  localparam int unsigned OUT_W      = 88;
  localparam int unsigned LIMIT      = 600000;
  localparam int unsigned PHASES     = 6;
  localparam int unsigned PHASE_ITEMS = 225;

  typedef struct packed {
    logic [CNT_W-1:0]  wb_cnt;
    logic [CNT_W-1:0]  fault_cnt;
    logic              ev_dirty;
    logic [PAGE_W-1:0] ev_page;
    logic              ev_valid;
    logic              hit;
  } outcome_t;

  class frame_scoreboard;
    outcome_t          pending_outcomes[$];
    bit                fv[FRAMES];
    logic [PAGE_W-1:0] fp[FRAMES];
    bit                fd[FRAMES];
    logic [31:0]       flu[FRAMES];
    logic [31:0]       now_t;
    logic [CNT_W-1:0]  faults;
    logic [CNT_W-1:0]  wbs;
    logic [CFG_W-1:0]  limit_reg;
    int                errors;

    function new();
      limit_reg = FRAMES_RESET;
      errors    = 0;
      clear_trace();
    endfunction

    function void clear_trace();
      for (int i = 0; i < FRAMES; i++) begin
        fv[i]  = 1'b0;
        fp[i]  = '0;
        fd[i]  = 1'b0;
        flu[i] = '0;
      end
      now_t  = '0;
      faults = '0;
      wbs    = '0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit_reg = v;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void mismatch(string what, longint unsigned e, longint unsigned a);
      if (errors < 10) $display("%0t %s: expected %0h, got %0h", $time, what, e, a);
      errors++;
    endfunction

    function void note_access(logic [PAGE_W-1:0] page, bit wr, bit last);
      outcome_t    o;
      int          match;
      int          free_slot;
      int          victim;
      int          slot;
      int          used;
      int          lim;
      logic [31:0] age;
      logic [31:0] oldest;
      o         = '0;
      match     = -1;
      free_slot = -1;
      victim    = -1;
      used      = 0;
      oldest    = '0;
      lim       = (limit_reg == 0) ? 1 : ((limit_reg > FRAMES) ? FRAMES : int'(limit_reg));
      for (int i = 0; i < FRAMES; i++) begin
        if (fv[i]) begin
          age = now_t - flu[i];
          used++;
          if (match < 0 && fp[i] == page) match = i;
          if (victim < 0 || age > oldest) begin
            victim = i;
            oldest = age;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (match >= 0) begin
        o.hit = 1'b1;
        if (wr) fd[match] = 1'b1;
        flu[match] = now_t;
      end else begin
        if (used < lim && free_slot >= 0) begin
          slot = free_slot;
        end else begin
          slot       = victim;
          o.ev_valid = 1'b1;
          o.ev_page  = fp[slot];
          o.ev_dirty = fd[slot];
          if (fd[slot] && wbs != '1) wbs++;
        end
        fv[slot]  = 1'b1;
        fp[slot]  = page;
        fd[slot]  = wr;
        flu[slot] = now_t;
        if (faults != '1) faults++;
      end
      now_t++;
      o.fault_cnt = faults;
      o.wb_cnt    = wbs;
      pending_outcomes = {pending_outcomes, o};
      if (last) clear_trace();
    endfunction

    function void check_reply(logic [OUT_W-1:0] word);
      outcome_t e;
      outcome_t a;
      if (pending_outcomes.size() == 0) begin
        mismatch("unexpected reply word", 0, word[63:0]);
        return;
      end
      e = pending_outcomes.pop_front();
      a = outcome_t'(word[$bits(outcome_t)-1:0]);
      if (a.hit != e.hit) mismatch("hit", e.hit, a.hit);
      if (a.ev_valid != e.ev_valid) mismatch("evicted_valid", e.ev_valid, a.ev_valid);
      if (a.ev_page != e.ev_page) mismatch("evicted_page", e.ev_page, a.ev_page);
      if (a.ev_dirty != e.ev_dirty) mismatch("evicted_dirty", e.ev_dirty, a.ev_dirty);
      if (a.fault_cnt != e.fault_cnt) mismatch("fault_count", e.fault_cnt, a.fault_cnt);
      if (a.wb_cnt != e.wb_cnt) mismatch("writeback_count", e.wb_cnt, a.wb_cnt);
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;   // page_number, zero pad
  logic                  s_axis_tuser  = 1'b0; // is_write
  logic                  s_axis_tlast  = 1'b0; // end_of_trace
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // hit, evicted_valid, evicted_page, evicted_dirty, fault_count,
  // writeback_count, zero pad
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  frame_scoreboard sb = new();
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int unsigned     cycles        = 0;

  lru_page_replacement_dirty_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_access(input logic [PAGE_W-1:0] page, input bit wr, input bit last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-PAGE_W){1'b0}}, page};
    s_axis_tuser  <= wr;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_access(page, wr, last);
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic set_frame_limit(input logic [CFG_W-1:0] v);
    logic [APB_DATA_W-1:0] wval;
    wval    = APB_DATA_W'({$urandom(), v});
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FRAMES_IN_USE, 2'b00};
    pwdata  <= wval;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_limit(v);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata != APB_DATA_W'(v)) sb.mismatch("frames_in_use readback", v, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [PAGE_W-1:0] page_pool[24];
    logic [CFG_W-1:0]  phase_cfg[PHASES];
    logic [PAGE_W-1:0] page;
    int                pool_size;
    int                eff;
    int                r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill all frames at the reset limit, then lower the limit below occupancy
    for (int k = 0; k < FRAMES; k++) begin
      if (k == 0) page = '0;
      else if (k == 1) page = '1;
      else page = {k[3:0], 16'h5A5A ^ 16'(k)};
      send_access(page, k[0], 1'b0);
    end
    send_access('0, 1'b1, 1'b0);
    drain_replies();
    set_frame_limit(5'd3);
    send_access(20'hABCDE, 1'b0, 1'b0);
    send_access(20'h00001, 1'b1, 1'b0);
    send_access('0, 1'b0, 1'b1);
    drain_replies();
    set_frame_limit(5'd2);
    send_access(20'h00F0F, 1'b0, 1'b0);
    send_access(20'hF0F0F, 1'b1, 1'b0);
    send_access(20'h00F0F, 1'b1, 1'b0);
    send_access(20'h33333, 1'b0, 1'b1);
    drain_replies();
    set_frame_limit(5'd0);
    send_access(20'h55555, 1'b1, 1'b0);
    send_access(20'hAAAAA, 1'b0, 1'b1);

    phase_cfg = '{5'd31, 5'd1, 5'd16, 5'd17, CFG_W'($urandom_range(1, 31)), 5'd8};
    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      set_frame_limit(phase_cfg[p]);
      if (p < 2) begin
        send_idle_pct = 32;
        recv_idle_pct = 51;
      end else if (p < 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      eff = (phase_cfg[p] == 0) ? 1 : ((phase_cfg[p] > FRAMES) ? FRAMES : int'(phase_cfg[p]));
      pool_size = eff + 1 + $urandom_range(0, 4);
      for (int j = 0; j < pool_size; j++) page_pool[j] = PAGE_W'($urandom());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_replies();
        r = $urandom_range(0, 99);
        if (r < 85) page = page_pool[$urandom_range(0, pool_size - 1)];
        else if (r < 95) page = PAGE_W'($urandom());
        else if (r < 97) page = '0;
        else if (r < 99) page = '1;
        else page = PAGE_W'(1) << $urandom_range(0, PAGE_W - 1);
        send_access(page, 1'($urandom_range(0, 1)), ($urandom_range(0, 39) == 0));
      end
    end

    drain_replies();
    repeat (2 * (FRAMES + 3)) @(posedge clk_i);
    if (sb.pending() != 0) sb.mismatch("replies left over", 0, sb.pending());
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
